// ----- src/distinct_byte_histogram_macros.svh -----
// assertion macros for the distinct byte histogram
`ifndef DISTINCT_BYTE_HISTOGRAM_MACROS_SVH
`define DISTINCT_BYTE_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
`define DBH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("distinct_byte_histogram: same-cycle check failed");
`define DBH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("distinct_byte_histogram: next-cycle check failed");
`else
`define DBH_ASSERT_IMPL(lbl, ante, cons)
`define DBH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/dbh_pkg.sv -----
// shared constants and command codes for the distinct byte histogram
package dbh_pkg;
	localparam int DEF_BUFFER_SIZE = 256;
	localparam int SYM_W = 8;
	localparam int SYMS = 1 << SYM_W;
	localparam int TOTAL_W = SYM_W + 1;
	localparam logic [SYM_W-1:0] CNT_MAX = '1;
	localparam logic [SYM_W-1:0] END_BYTE = '0;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_FETCH  = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;
endpackage

// ----- src/distinct_byte_histogram.sv -----
// distinct byte histogram top level with count and order memories
//
// Input channel (in_valid/in_ready) carries cmd and text_byte. A load adds one
// byte of text, a zero byte ends the text, and later loads are ignored. Text
// beyond BUFFER_SIZE-1 bytes is dropped. Clear and rewind complete on the
// transfer. A load reads the count memory on the transfer and writes the
// incremented count back in the next cycle. A fetch reads the order memory
// on the transfer, then the count memory at the returned symbol in S_F1,
// then registers the result in S_F2.
// Only a fetch produces a result on the output channel (out_valid/out_ready):
// symbol, occurrences, is_last and is_valid, with is_valid low once the list
// is exhausted. The output register holds a result while the receiver stalls;
// loads, clears and rewinds are still taken meanwhile, and a further fetch
// waits in its last cycle until the register frees.
// A new command is taken only in idle, after the previous load or fetch has
// finished. Reset clears the valid bits, counters and pointers at once;
// the memories themselves are not cleared and are read through the valid bits.
module distinct_byte_histogram
	import dbh_pkg::*;
#(
	parameter int BUFFER_SIZE = DEF_BUFFER_SIZE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  logic [SYM_W-1:0] text_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SYM_W-1:0] symbol,
	output logic [SYM_W-1:0] occurrences,
	output logic             is_last,
	output logic             is_valid
);
	localparam int LEN_W = $clog2(BUFFER_SIZE);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_SIZE - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_F1   = 4'b0100,
		S_F2   = 4'b1000
	} state_t;

	state_t state_q;

	logic [SYM_W-1:0]   cnt_mem [SYMS];
	logic [SYM_W-1:0]   ord_mem [SYMS];
	logic [SYMS-1:0]    cnt_valid_q;
	logic [SYM_W-1:0]   cnt_rd_q;
	logic [SYM_W-1:0]   ord_rd_q;
	logic [SYM_W-1:0]   byte_s1;
	logic [TOTAL_W-1:0] distinct_q;
	logic [TOTAL_W-1:0] fp_q;
	logic [LEN_W-1:0]   len_q;
	logic               ended_q;

	logic               out_valid_q;
	logic [SYM_W-1:0]   symbol_q;
	logic [SYM_W-1:0]   occ_q;
	logic               last_q;
	logic               isv_q;

	logic               in_xfer;
	logic               cnt_re;
	logic [SYM_W-1:0]   cnt_raddr;
	logic               cnt_we;
	logic [SYM_W-1:0]   cnt_new;
	logic               is_new;
	logic               out_free;
	logic               hit;
	logic [SYM_W-1:0]   fetch_cnt;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign cnt_re    = (in_xfer && cmd == CMD_LOAD) || (state_q == S_F1);
	assign cnt_raddr = (state_q == S_F1) ? ord_rd_q : text_byte;

	assign is_new    = !cnt_valid_q[byte_s1];
	assign cnt_we    = (state_q == S_LOAD) && !ended_q && (byte_s1 != END_BYTE)
		&& (len_q < LEN_MAX);
	assign cnt_new   = is_new ? SYM_W'(1) : ((cnt_rd_q == CNT_MAX) ? cnt_rd_q
		: cnt_rd_q + SYM_W'(1));

	assign hit       = fp_q < distinct_q;
	assign fetch_cnt = cnt_valid_q[ord_rd_q] ? cnt_rd_q : '0;

	// memories
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[byte_s1] <= cnt_new;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
		if (cnt_we && is_new) begin
			ord_mem[distinct_q[SYM_W-1:0]] <= byte_s1;
		end
		if (in_xfer && cmd == CMD_FETCH) begin
			ord_rd_q <= ord_mem[fp_q[SYM_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_valid_q <= '0;
			distinct_q  <= '0;
			fp_q        <= '0;
			len_q       <= '0;
			ended_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						unique case (cmd)
							CMD_CLEAR: begin
								cnt_valid_q <= '0;
								distinct_q  <= '0;
								fp_q        <= '0;
								len_q       <= '0;
								ended_q     <= 1'b0;
							end
							CMD_LOAD:   state_q <= S_LOAD;
							CMD_FETCH:  state_q <= S_F1;
							CMD_REWIND: fp_q <= '0;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: begin
					state_q <= S_IDLE;
					if (!ended_q && byte_s1 == END_BYTE) begin
						ended_q <= 1'b1;
					end
					if (cnt_we) begin
						len_q                <= len_q + LEN_W'(1);
						cnt_valid_q[byte_s1] <= 1'b1;
						if (is_new) begin
							distinct_q <= distinct_q + TOTAL_W'(1);
						end
					end
				end
				S_F1: state_q <= S_F2;
				S_F2: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (hit) begin
							fp_q <= fp_q + TOTAL_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_F2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_F2 && out_free) begin
			symbol_q <= hit ? ord_rd_q : '0;
			occ_q    <= hit ? fetch_cnt : '0;
			last_q   <= hit && (fp_q + TOTAL_W'(1) == distinct_q);
			isv_q    <= hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = symbol_q;
	assign occurrences = occ_q;
	assign is_last     = last_q;
	assign is_valid    = isv_q;

`include "distinct_byte_histogram_macros.svh"

	`DBH_ASSERT_IMPL(a_distinct_bound, 1'b1, distinct_q <= TOTAL_W'(SYMS - 1))
	`DBH_ASSERT_IMPL(a_fp_bound, 1'b1, fp_q <= distinct_q)
	`DBH_ASSERT_IMPL(a_valid_count, out_valid_q && isv_q, occ_q != '0)
	`DBH_ASSERT_NEXT(a_fetch_result, state_q == S_F2 && out_free, out_valid_q)
endmodule
